### rtl/apt_pkg.sv
// Shared types and constants for the bounding box projective transform.
// No dependencies; every other file of the block refers to it by scoped names.
package apt_pkg;

    // Fixed-point format of coordinates and matrix coefficients.
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // Port field width and register count.
    localparam int FIELD_W      = 32;
    localparam int PAIR_W       = 64;
    localparam int MATRIX_PAIRS = 8;
    localparam int CFG_IDX_W    = 4;

    // Exact products, accumulated sums and their magnitudes.
    localparam int PROD_W = 2 * COORD_WIDTH;
    localparam int ACC_W  = 2 * COORD_WIDTH + 2;
    localparam int MAG_W  = 2 * COORD_WIDTH;

    // Numerator bits still to be fed after the initial remainder is formed.
    localparam int SHIFT_W = COORD_WIDTH - FRAC_BITS;

    // Stage counts of the three pipeline parts.
    localparam int MAC_STAGES    = 2;
    localparam int DIV_STAGES    = COORD_WIDTH + 3;
    localparam int MINMAX_STAGES = 3;
    localparam int PIPE_DEPTH    = MAC_STAGES + DIV_STAGES + MINMAX_STAGES;

    // Register reset values: identity matrix.
    localparam logic [PAIR_W-1:0] ONE_LOW  = PAIR_W'(1) << FRAC_BITS;
    localparam logic [PAIR_W-1:0] ONE_HIGH = PAIR_W'(1) << (FIELD_W + FRAC_BITS);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [ACC_W-1:0]       acc_t;
    typedef logic        [MAG_W-1:0]       mag_t;

    // Per-quotient flags that travel with the remainder through the divider.
    typedef struct packed {
        logic q_neg;
        logic n_neg;
        logic w_zero;
        logic n_zero;
        logic ovf;
    } div_flags_t;

endpackage

### rtl/apt_corner_mac.sv
// Corner products and row sums: eight corners times four matrix rows.
// Depends on apt_pkg for widths and types.
module apt_corner_mac (
    input  logic            aclk,
    input  logic            en,
    input  apt_pkg::coord_t box_lo [3],
    input  apt_pkg::coord_t box_hi [3],
    input  apt_pkg::coord_t coef   [4][4],
    output apt_pkg::acc_t   acc    [8][4]
);

    apt_pkg::prod_t prod_reg  [4][3][2];
    apt_pkg::prod_t prod_next [4][3][2];
    apt_pkg::acc_t  acc_reg   [8][4];
    apt_pkg::acc_t  acc_next  [8][4];

    // Each corner picks the lower or upper bound per axis, so only two
    // products per coefficient are needed.
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int a = 0; a < 3; a++) begin
                prod_next[r][a][0] = coef[r][a] * box_lo[a];
                prod_next[r][a][1] = coef[r][a] * box_hi[a];
            end
        end
    end

    // Row sums per corner with the translation term scaled to product format.
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            for (int r = 0; r < 4; r++) begin
                acc_next[k][r] = apt_pkg::ACC_W'(prod_reg[r][0][((k & 4) != 0) ? 1 : 0])
                               + apt_pkg::ACC_W'(prod_reg[r][1][((k & 2) != 0) ? 1 : 0])
                               + apt_pkg::ACC_W'(prod_reg[r][2][((k & 1) != 0) ? 1 : 0])
                               + (apt_pkg::ACC_W'(coef[r][3]) <<< apt_pkg::FRAC_BITS);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

### rtl/apt_div_pipe.sv
// Pipelined restoring divider: one quotient bit per stage, with saturation.
// Depends on apt_pkg for widths, types and the flag struct.
module apt_div_pipe (
    input  logic            aclk,
    input  logic            en,
    input  apt_pkg::acc_t   num_in,
    input  apt_pkg::acc_t   den_in,
    output apt_pkg::coord_t quot_out,
    output logic            fault_out
);

    localparam int C = apt_pkg::COORD_WIDTH;
    localparam int M = apt_pkg::MAG_W;
    localparam int S = apt_pkg::SHIFT_W;

    // Magnitude stage.
    apt_pkg::acc_t n_abs;
    apt_pkg::acc_t w_abs;
    apt_pkg::mag_t n_mag_reg;
    apt_pkg::mag_t w_mag_reg;
    logic          n_neg_reg;
    logic          w_neg_reg;

    always_comb begin
        n_abs = num_in[apt_pkg::ACC_W-1] ? -num_in : num_in;
        w_abs = den_in[apt_pkg::ACC_W-1] ? -den_in : den_in;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_mag_reg <= n_abs[M-1:0];
            w_mag_reg <= w_abs[M-1:0];
            n_neg_reg <= num_in[apt_pkg::ACC_W-1];
            w_neg_reg <= den_in[apt_pkg::ACC_W-1];
        end
    end

    // Setup stage and bit stages; index 0 holds the setup result.
    apt_pkg::mag_t       rem_reg   [0:C];
    apt_pkg::mag_t       den_reg   [0:C];
    logic [C-1:0]        q_reg     [0:C];
    logic [S-1:0]        bits_reg  [0:C];
    apt_pkg::div_flags_t flags_reg [0:C];

    apt_pkg::mag_t       rem0;
    apt_pkg::div_flags_t flags0;

    // Initial remainder is the numerator without its low bits; the quotient
    // fits the coordinate width only when that remainder is below the divisor.
    always_comb begin
        rem0          = n_mag_reg >> S;
        flags0.q_neg  = n_neg_reg ^ w_neg_reg;
        flags0.n_neg  = n_neg_reg;
        flags0.w_zero = (w_mag_reg == '0);
        flags0.n_zero = (n_mag_reg == '0);
        flags0.ovf    = (rem0 >= w_mag_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]   <= rem0;
            den_reg[0]   <= w_mag_reg;
            q_reg[0]     <= '0;
            bits_reg[0]  <= n_mag_reg[S-1:0];
            flags_reg[0] <= flags0;
        end
    end

    for (genvar j = 0; j < C; j++) begin : g_step
        logic [M:0] trial;
        logic [M:0] diff;
        logic       ge;

        // Shift in the next numerator bit and subtract the divisor if it fits.
        always_comb begin
            trial = {rem_reg[j], bits_reg[j][S-1]};
            diff  = trial - {1'b0, den_reg[j]};
            ge    = (trial >= {1'b0, den_reg[j]});
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j+1]   <= ge ? diff[M-1:0] : trial[M-1:0];
                den_reg[j+1]   <= den_reg[j];
                q_reg[j+1]     <= {q_reg[j][C-2:0], ge};
                bits_reg[j+1]  <= bits_reg[j] << 1;
                flags_reg[j+1] <= flags_reg[j];
            end
        end
    end

    // Sign and saturation.
    localparam logic [C-1:0] MAX_POS = {1'b0, {(C-1){1'b1}}};
    localparam logic [C-1:0] MIN_NEG = {1'b1, {(C-1){1'b0}}};

    logic [C-1:0]        q_fin;
    apt_pkg::div_flags_t f_fin;
    logic [C-1:0]        res_next;
    logic                fault_next;
    apt_pkg::coord_t     quot_reg;
    logic                fault_reg;

    always_comb begin
        q_fin = q_reg[C];
        f_fin = flags_reg[C];
        priority if (f_fin.w_zero) begin
            fault_next = 1'b1;
            if (f_fin.n_zero) begin
                res_next = '0;
            end else begin
                res_next = f_fin.n_neg ? MIN_NEG : MAX_POS;
            end
        end else if (!f_fin.q_neg) begin
            fault_next = f_fin.ovf || q_fin[C-1];
            res_next   = fault_next ? MAX_POS : q_fin;
        end else begin
            fault_next = f_fin.ovf || (q_fin > MIN_NEG);
            res_next   = fault_next ? MIN_NEG : (C'(0) - q_fin);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quot_reg  <= res_next;
            fault_reg <= fault_next;
        end
    end

    assign quot_out  = quot_reg;
    assign fault_out = fault_reg;

endmodule

### rtl/apt_minmax.sv
// Registered min/max tree over the eight projected corners, plus fault merge.
// Depends on apt_pkg for the coordinate type.
module apt_minmax (
    input  logic            aclk,
    input  logic            en,
    input  apt_pkg::coord_t quot  [8][3],
    input  logic            fault [8][3],
    output apt_pkg::coord_t mn    [3],
    output apt_pkg::coord_t mx    [3],
    output logic            fault_any
);

    apt_pkg::coord_t mn1_reg [4][3];
    apt_pkg::coord_t mx1_reg [4][3];
    apt_pkg::coord_t mn2_reg [2][3];
    apt_pkg::coord_t mx2_reg [2][3];
    apt_pkg::coord_t mn3_reg [3];
    apt_pkg::coord_t mx3_reg [3];
    logic            f1_reg;
    logic            f2_reg;
    logic            f3_reg;

    apt_pkg::coord_t mn1_next [4][3];
    apt_pkg::coord_t mx1_next [4][3];
    apt_pkg::coord_t mn2_next [2][3];
    apt_pkg::coord_t mx2_next [2][3];
    apt_pkg::coord_t mn3_next [3];
    apt_pkg::coord_t mx3_next [3];
    logic            f1_next;

    // First level compares corner pairs and merges all fault flags.
    always_comb begin
        f1_next = 1'b0;
        for (int i = 0; i < 4; i++) begin
            for (int a = 0; a < 3; a++) begin
                mn1_next[i][a] = (quot[2*i+1][a] < quot[2*i][a]) ?
                                 quot[2*i+1][a] : quot[2*i][a];
                mx1_next[i][a] = (quot[2*i+1][a] > quot[2*i][a]) ?
                                 quot[2*i+1][a] : quot[2*i][a];
            end
        end
        for (int k = 0; k < 8; k++) begin
            for (int a = 0; a < 3; a++) begin
                f1_next = f1_next | fault[k][a];
            end
        end
    end

    // Second and third levels.
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            for (int a = 0; a < 3; a++) begin
                mn2_next[i][a] = (mn1_reg[2*i+1][a] < mn1_reg[2*i][a]) ?
                                 mn1_reg[2*i+1][a] : mn1_reg[2*i][a];
                mx2_next[i][a] = (mx1_reg[2*i+1][a] > mx1_reg[2*i][a]) ?
                                 mx1_reg[2*i+1][a] : mx1_reg[2*i][a];
            end
        end
        for (int a = 0; a < 3; a++) begin
            mn3_next[a] = (mn2_reg[1][a] < mn2_reg[0][a]) ? mn2_reg[1][a] : mn2_reg[0][a];
            mx3_next[a] = (mx2_reg[1][a] > mx2_reg[0][a]) ? mx2_reg[1][a] : mx2_reg[0][a];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mn1_reg <= mn1_next;
            mx1_reg <= mx1_next;
            f1_reg  <= f1_next;
            mn2_reg <= mn2_next;
            mx2_reg <= mx2_next;
            f2_reg  <= f1_reg;
            mn3_reg <= mn3_next;
            mx3_reg <= mx3_next;
            f3_reg  <= f2_reg;
        end
    end

    assign mn        = mn3_reg;
    assign mx        = mx3_reg;
    assign fault_any = f3_reg;

endmodule

### rtl/aabb_projective_transform.sv
// Top level of the bounding box projective transform.
// Depends on apt_pkg, apt_corner_mac, apt_div_pipe and apt_minmax.
//
// Usage:
//   The slave channel takes one box per request on s_tdata (lower corner
//   x, y, z, then upper corner x, y, z, signed Q16.16). The master channel
//   returns the projected box on m_tdata (per-axis minimum x, y, z, then
//   maximum x, y, z) and a divide fault flag on m_tuser.
//   The 4x4 matrix is loaded through cfg_wr_en / cfg_index / cfg_wr_data,
//   two coefficients per register; indexes above seven are ignored. Load it
//   only while no box is in flight.
//   The pipeline has two stages of multiply and row sum, 35 stages of the
//   divider (magnitude, setup, one per quotient bit, sign and saturation),
//   and three stages of the min/max tree, the last being the output
//   register. A new box is accepted every cycle unless the output stalls.
//   Reset clears all valid bits and loads the identity matrix.
//   When m_tready is low with a result waiting, the whole pipeline holds and
//   s_tready drops; nothing is lost or repeated.
module aabb_projective_transform (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port.
    input  logic                          cfg_wr_en,
    input  logic [apt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [apt_pkg::PAIR_W-1:0]    cfg_wr_data,
    // Input boxes.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    input  logic [6*apt_pkg::FIELD_W-1:0] s_tdata,
    // Projected boxes.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z
    output logic [6*apt_pkg::FIELD_W-1:0] m_tdata,
    // divide_fault
    output logic                          m_tuser
);

    localparam int C = apt_pkg::COORD_WIDTH;
    localparam int W = apt_pkg::FIELD_W;
    localparam int D = apt_pkg::PIPE_DEPTH;

    // Matrix registers.
    logic [apt_pkg::PAIR_W-1:0] matrix_pair_reg [apt_pkg::MATRIX_PAIRS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < apt_pkg::MATRIX_PAIRS; i++) begin
                if (i == 0 || i == 5) begin
                    matrix_pair_reg[i] <= apt_pkg::ONE_HIGH;
                end else if (i == 2 || i == 7) begin
                    matrix_pair_reg[i] <= apt_pkg::ONE_LOW;
                end else begin
                    matrix_pair_reg[i] <= '0;
                end
            end
        end else if (cfg_wr_en &&
                     (cfg_index < apt_pkg::CFG_IDX_W'(apt_pkg::MATRIX_PAIRS))) begin
            matrix_pair_reg[cfg_index[$clog2(apt_pkg::MATRIX_PAIRS)-1:0]] <= cfg_wr_data;
        end
    end

    // Coefficient unpacking: even register of a row holds columns 0 and 1.
    apt_pkg::coord_t coef [4][4];

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            coef[r][0] = matrix_pair_reg[2*r][W +: C];
            coef[r][1] = matrix_pair_reg[2*r][0 +: C];
            coef[r][2] = matrix_pair_reg[2*r+1][W +: C];
            coef[r][3] = matrix_pair_reg[2*r+1][0 +: C];
        end
    end

    // Input fields.
    apt_pkg::coord_t box_lo [3];
    apt_pkg::coord_t box_hi [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            box_lo[a] = s_tdata[W*a +: C];
            box_hi[a] = s_tdata[W*(a+3) +: C];
        end
    end

    // Global advance: the pipeline moves whenever the output slot is free
    // or being taken.
    logic         adv;
    logic [D-1:0] valid_reg;
    logic [D-1:0] valid_next;

    assign adv      = !valid_reg[D-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = valid_reg[D-1];

    always_comb begin
        valid_next = {valid_reg[D-2:0], s_tvalid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= valid_next;
        end
    end

    // Multiply and row sums.
    apt_pkg::acc_t acc [8][4];

    apt_corner_mac u_mac (
        .aclk   (aclk),
        .en     (adv),
        .box_lo (box_lo),
        .box_hi (box_hi),
        .coef   (coef),
        .acc    (acc)
    );

    // One divider per corner and axis.
    apt_pkg::coord_t quot  [8][3];
    logic            fault [8][3];

    for (genvar k = 0; k < 8; k++) begin : g_corner
        for (genvar a = 0; a < 3; a++) begin : g_axis
            apt_div_pipe u_div (
                .aclk      (aclk),
                .en        (adv),
                .num_in    (acc[k][a]),
                .den_in    (acc[k][3]),
                .quot_out  (quot[k][a]),
                .fault_out (fault[k][a])
            );
        end
    end

    // Reduction over corners; its last level is the output register.
    apt_pkg::coord_t mn [3];
    apt_pkg::coord_t mx [3];
    logic            fault_any;

    apt_minmax u_minmax (
        .aclk      (aclk),
        .en        (adv),
        .quot      (quot),
        .fault     (fault),
        .mn        (mn),
        .mx        (mx),
        .fault_any (fault_any)
    );

    // Output packing with sign extension to the field width.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            m_tdata[W*a +: W]     = W'(mn[a]);
            m_tdata[W*(a+3) +: W] = W'(mx[a]);
        end
    end

    assign m_tuser = fault_any;

endmodule

### bench/aabb_projective_transform_checker.sv
// Checker for the bounding box projective transform: watches the config port and both
// streams, predicts each projected box and compares it with what the block returns.
// Depends on apt_pkg.
module aabb_projective_transform_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [apt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [apt_pkg::PAIR_W-1:0]    cfg_wr_data,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [6*apt_pkg::FIELD_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [6*apt_pkg::FIELD_W-1:0] m_tdata,
    input  logic                          m_tuser,
    output int                            fail_count,
    output int                            boxes_pending
);
    import apt_pkg::*;

    typedef struct {
        logic [6*FIELD_W-1:0] bounds;
        logic                 fault;
    } projected_box_t;

    logic [PAIR_W-1:0] matrix_regs [MATRIX_PAIRS];
    projected_box_t    box_queue [$];

    // Signed coefficient of row r, column c.
    function automatic longint coef_at(int r, int c);
        logic [PAIR_W-1:0] pair;
        logic [31:0]       half;
        pair = matrix_regs[r * 2 + c / 2];
        half = (c % 2) ? pair[31:0] : pair[63:32];
        return longint'($signed(half[COORD_WIDTH-1:0]));
    endfunction

    // Divide with truncation toward zero, saturating; w == 0 saturates by numerator sign.
    function automatic longint quotient_sat(logic signed [127:0] num,
                                            logic signed [127:0] den, ref logic fault);
        logic signed [127:0] q;
        longint              maxv;
        longint              minv;
        maxv = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
        minv = -(64'sd1 <<< (COORD_WIDTH - 1));
        if (den == 0) begin
            fault = 1'b1;
            if (num == 0) return 0;
            return (num < 0) ? minv : maxv;
        end
        q = (num <<< FRAC_BITS) / den;
        if (q > maxv) begin
            fault = 1'b1;
            return maxv;
        end
        if (q < minv) begin
            fault = 1'b1;
            return minv;
        end
        return longint'(q);
    endfunction

    function automatic projected_box_t project_box(logic [6*FIELD_W-1:0] box);
        projected_box_t      res;
        longint              lo [3];
        longint              hi [3];
        longint              mn [3];
        longint              mx [3];
        longint              v [3];
        logic signed [127:0] acc [4];
        longint              q;
        logic                fault;
        fault = 1'b0;
        for (int a = 0; a < 3; a++) begin
            lo[a] = longint'($signed(box[a*FIELD_W +: COORD_WIDTH]));
            hi[a] = longint'($signed(box[(a+3)*FIELD_W +: COORD_WIDTH]));
        end
        for (int k = 0; k < 8; k++) begin
            v[0] = (k & 4) ? hi[0] : lo[0];
            v[1] = (k & 2) ? hi[1] : lo[1];
            v[2] = (k & 1) ? hi[2] : lo[2];
            for (int r = 0; r < 4; r++) begin
                acc[r] = 128'(coef_at(r, 3)) * (128'sd1 <<< FRAC_BITS);
                for (int a = 0; a < 3; a++)
                    acc[r] += 128'(coef_at(r, a)) * 128'(v[a]);
            end
            for (int a = 0; a < 3; a++) begin
                q = quotient_sat(acc[a], acc[3], fault);
                if (k == 0 || q < mn[a]) mn[a] = q;
                if (k == 0 || q > mx[a]) mx[a] = q;
            end
        end
        for (int a = 0; a < 3; a++) begin
            res.bounds[a*FIELD_W +: FIELD_W]     = 32'(mn[a]);
            res.bounds[(a+3)*FIELD_W +: FIELD_W] = 32'(mx[a]);
        end
        res.fault = fault;
        return res;
    endfunction

    assign boxes_pending = box_queue.size();

    // Track register writes, queue predictions and compare results.
    always @(posedge aclk) begin
        projected_box_t want;
        int             errs;
        errs = 0;
        if (!aresetn) begin
            for (int i = 0; i < MATRIX_PAIRS; i++) begin
                if (i == 0 || i == 5) matrix_regs[i] <= ONE_HIGH;
                else if (i == 2 || i == 7) matrix_regs[i] <= ONE_LOW;
                else matrix_regs[i] <= '0;
            end
            fail_count <= 0;
        end else begin
            if (cfg_wr_en && cfg_index < MATRIX_PAIRS)
                matrix_regs[cfg_index] <= cfg_wr_data;
            if (s_tvalid && s_tready)
                box_queue.push_back(project_box(s_tdata));
            if (m_tvalid && m_tready) begin
                if (box_queue.size() == 0) begin
                    $display("%0t: unexpected result %h fault %b", $time, m_tdata, m_tuser);
                    errs++;
                end else begin
                    want = box_queue.pop_front();
                    for (int f = 0; f < 6; f++)
                        if (m_tdata[f*FIELD_W +: FIELD_W] !== want.bounds[f*FIELD_W +: FIELD_W])
                        begin
                            $display("%0t: field %0d expected %h actual %h", $time, f,
                                     want.bounds[f*FIELD_W +: FIELD_W],
                                     m_tdata[f*FIELD_W +: FIELD_W]);
                            errs++;
                        end
                    if (m_tuser !== want.fault) begin
                        $display("%0t: fault expected %b actual %b", $time, want.fault, m_tuser);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
        end
    end
endmodule

### bench/aabb_projective_transform_tb.sv
// Testbench top for the bounding box projective transform: clock, reset, stimulus
// and verdict. Depends on apt_pkg, the block and aabb_projective_transform_checker.
module aabb_projective_transform_tb;
    import apt_pkg::*;

    localparam logic [31:0] ONE_Q = 32'h0001_0000;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [PAIR_W-1:0]      cfg_wr_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [6*FIELD_W-1:0]   s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [6*FIELD_W-1:0]   m_tdata;
    logic                   m_tuser;
    int                     fail_count;
    int                     boxes_pending;
    bit                     sink_steady = 1'b0;
    bit                     sink_hold = 1'b0;

    always #10 aclk = ~aclk;

    aabb_projective_transform dut (.*);
    aabb_projective_transform_checker checker_i (.*);

    // Result side: random stalls, with steady and long hold-off stretches.
    always @(posedge aclk) begin
        if (!aresetn || sink_hold) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= sink_steady || ($urandom_range(99) >= 20);
        end
    end

    // One register write, then the write port is left idle before the task returns.
    task automatic write_reg(int idx, logic [PAIR_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_IDX_W'(idx);
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [PAIR_W-1:0] pack_pair(logic [31:0] hi_c, logic [31:0] lo_c);
        return {hi_c, lo_c};
    endfunction

    // Stop offering, wait for every outstanding box, then let the pipeline drain.
    task automatic drain_boxes();
        s_tvalid <= 1'b0;
        while (boxes_pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    // Offer one box and hold it until accepted; optional random idle first.
    // The valid line stays high afterwards until the next gap or drain.
    task automatic send_box(logic [6*FIELD_W-1:0] box, bit allow_gap);
        if (allow_gap) begin
            while ($urandom_range(99) < 20) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= box;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord(int spread);
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(3))
            0:       return v;
            1:       return 32'($signed(v) >>> spread);
            2:       return {$urandom_range(1) ? 16'hFFFF : 16'h0000, v[15:0]};
            default: return 32'($signed(v) >>> 12);
        endcase
    endfunction

    function automatic logic [6*FIELD_W-1:0] rand_box();
        logic [6*FIELD_W-1:0] b;
        for (int f = 0; f < 6; f++) b[f*FIELD_W +: FIELD_W] = rand_coord($urandom_range(8, 20));
        return b;
    endfunction

    // Random matrix: mostly affine with a unit last row, sometimes fully projective.
    task automatic load_random_matrix(bit projective);
        for (int i = 0; i < MATRIX_PAIRS; i++)
            write_reg(i, {rand_coord(14), rand_coord(14)});
        if (!projective) begin
            write_reg(6, '0);
            write_reg(7, pack_pair('0, ONE_Q));
        end
    endtask

    task automatic send_random(int count, bit allow_gap);
        for (int n = 0; n < count; n++) send_box(rand_box(), allow_gap);
    endtask

    initial begin
        logic [31:0] mx;
        logic [31:0] mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed boxes on the reset identity matrix: extremes and swapped bounds.
        sink_steady = 1'b1;
        send_box({6{32'h0}}, 0);
        send_box({mx, mx, mx, mn, mn, mn}, 0);
        send_box({mn, mn, mn, mx, mx, mx}, 0);
        send_box({32'hFFFF_0000, ONE_Q, 32'h0002_8000, 32'hFFFE_0000, 32'h0, ONE_Q}, 0);
        send_box({32'hAAAA_5555, 32'h5555_AAAA, 32'hFFFF_FFFF, 32'h1, 32'h8000_0001,
                  32'h7FFF_FFFE}, 0);
        drain_boxes();

        // Zero w everywhere: saturation by numerator sign, and zero numerators.
        write_reg(7, '0);
        write_reg(15, '1);
        send_box({6{32'h0}}, 0);
        send_box({ONE_Q, ONE_Q, ONE_Q, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000}, 0);
        send_box({mx, mn, 32'h0, mn, mx, 32'h0}, 0);
        drain_boxes();

        // Tiny w: quotients overflow.
        write_reg(7, pack_pair('0, 32'h0000_0001));
        send_box({ONE_Q, 32'hFFFF_0000, 32'h10, 32'h0010_0000, 32'h0, 32'hFFF0_0000}, 0);
        send_box({mx, mx, mx, mn, mn, mn}, 0);
        drain_boxes();

        // All-ones matrix, all-zeros matrix with an extreme last row, then largest scale and translation.
        for (int i = 0; i < MATRIX_PAIRS; i++) write_reg(i, '1);
        send_box({ONE_Q, 32'h0, 32'hFFFF_0000, 32'h0002_0000, ONE_Q, 32'h0}, 0);
        send_box({mx, mx, mx, mn, mn, mn}, 0);
        drain_boxes();
        for (int i = 0; i < MATRIX_PAIRS; i++) write_reg(i, '0);
        write_reg(7, pack_pair(mx, mn));
        send_box({ONE_Q, 32'h0, 32'hFFFF_0000, 32'h0002_0000, ONE_Q, 32'h0}, 0);
        drain_boxes();
        write_reg(0, pack_pair(mx, mn));
        write_reg(1, pack_pair(mn, mx));
        write_reg(7, pack_pair('0, ONE_Q));
        send_box({mx, mx, mx, mn, mn, mn}, 0);
        send_box({32'h0003_0000, 32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0}, 0);
        drain_boxes();

        // Random phases across several matrices, with random gaps on both sides.
        sink_steady = 1'b0;
        for (int ph = 0; ph < 8; ph++) begin
            load_random_matrix(ph % 3 == 2);
            send_random(60, 1);
            drain_boxes();
        end

        // Long receiver hold-off while boxes keep coming, so the input stalls.
        sink_hold = 1'b1;
        fork
            send_random(60, 0);
            begin
                repeat (200) @(posedge aclk);
                sink_hold = 1'b0;
            end
        join
        drain_boxes();

        // Back-to-back boxes with no idling on either side, then more boxes with random gaps and stalls.
        sink_steady = 1'b1;
        load_random_matrix(0);
        send_random(60, 0);
        sink_steady = 1'b0;
        send_random(30, 1);
        drain_boxes();

        // Return to the identity matrix and finish.
        write_reg(0, {ONE_Q, 32'h0});
        write_reg(1, '0);
        write_reg(2, {32'h0, ONE_Q});
        write_reg(3, '0);
        write_reg(4, '0);
        write_reg(5, {ONE_Q, 32'h0});
        write_reg(6, '0);
        write_reg(7, {32'h0, ONE_Q});
        send_random(20, 1);
        drain_boxes();

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end
endmodule

### filelist.f
rtl/apt_pkg.sv
rtl/apt_corner_mac.sv
rtl/apt_div_pipe.sv
rtl/apt_minmax.sv
rtl/aabb_projective_transform.sv
bench/aabb_projective_transform_checker.sv
bench/aabb_projective_transform_tb.sv
